>>> hw/rtl/satl_pkg.sv
// ----------------------------------------------------------------------------
// satl_pkg
// Shared types and constants of the set-associative TLB with recency ranks.
// ----------------------------------------------------------------------------
package satl_pkg;

  localparam int DEF_WAYS             = 4;
  localparam int DEF_SETS             = 16;
  localparam int DEF_PAGE_OFFSET_BITS = 12;
  localparam int DEF_VA_BITS          = 48;

  localparam int REQ_W   = 2;
  localparam int VA_W    = 48;
  localparam int FRAME_W = 36;
  localparam int PA_W    = 48;
  localparam int REC_W   = 3;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 56;

  typedef enum logic [REQ_W-1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_PEEK      = 2'd1,
    REQ_CLEAR     = 2'd2
  } req_t;

  typedef struct packed {
    logic [PA_W-1:0]  pa;
    logic             hit;
    logic             fault;
    logic [REC_W-1:0] recency;
  } result_t;

endpackage

>>> hw/rtl/satl_ram.sv
// ----------------------------------------------------------------------------
// satl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/satl_lookup.sv
// ----------------------------------------------------------------------------
// satl_lookup
// Tag match, rank update and victim choice for one set of the TLB.
// ----------------------------------------------------------------------------
module satl_lookup #(
  parameter int WAYS             = satl_pkg::DEF_WAYS,
  parameter int TAG_W            = 32,
  parameter int RANK_W           = 3,
  parameter int PAGE_OFFSET_BITS = satl_pkg::DEF_PAGE_OFFSET_BITS,
  localparam int ENT_W = TAG_W + satl_pkg::FRAME_W + RANK_W,
  localparam int ROW_W = WAYS * ENT_W
) (
  input  logic [satl_pkg::REQ_W-1:0]   req,
  input  logic [TAG_W-1:0]             tag,
  input  logic [PAGE_OFFSET_BITS-1:0]  offset,
  input  logic [satl_pkg::FRAME_W-1:0] ppn,
  input  logic                         walk_fault,
  input  logic [WAYS-1:0]              valid,
  input  logic [ROW_W-1:0]             row,
  output logic [ROW_W-1:0]             row_next,
  output logic [WAYS-1:0]              valid_next,
  output logic                         wr_en,
  output satl_pkg::result_t            res
);

  logic [TAG_W-1:0]             tags   [WAYS];
  logic [satl_pkg::FRAME_W-1:0] frames [WAYS];
  logic [RANK_W-1:0]            ranks  [WAYS];
  logic [WAYS-1:0]              match;
  logic [WAYS-1:0]              hit_oh;
  logic [WAYS-1:0]              free_oh;
  logic [WAYS-1:0]              max_oh;
  logic [WAYS-1:0]              victim_oh;
  logic [RANK_W-1:0]            hit_rank;
  logic [31:0]                  hit_rank32;
  logic [satl_pkg::FRAME_W-1:0] hit_frame;
  logic [satl_pkg::FRAME_W-1:0] pa_frame;
  logic [63:0]                  pa_wide;
  logic                         any_hit;
  logic [RANK_W-1:0]            r;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ranks[w]  = row[w*ENT_W +: RANK_W];
      frames[w] = row[w*ENT_W + RANK_W +: satl_pkg::FRAME_W];
      tags[w]   = row[w*ENT_W + RANK_W + satl_pkg::FRAME_W +: TAG_W];
      match[w]  = valid[w] && (tags[w] == tag);
    end
    hit_oh  = match & (~match + WAYS'(1));
    free_oh = ~valid & (valid + WAYS'(1));
    // A way is the oldest when no earlier way is as old and no later way is older.
    for (int w = 0; w < WAYS; w++) begin
      max_oh[w] = (ranks[w] != '0);
      for (int j = 0; j < WAYS; j++) begin
        if (j < w && ranks[j] >= ranks[w]) begin
          max_oh[w] = 1'b0;
        end
        if (j > w && ranks[j] > ranks[w]) begin
          max_oh[w] = 1'b0;
        end
      end
    end
    if (|free_oh) begin
      victim_oh = free_oh;
    end else if (|max_oh) begin
      victim_oh = max_oh;
    end else begin
      victim_oh = WAYS'(1);
    end
    hit_rank  = '0;
    hit_frame = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_rank  = hit_rank | ranks[w];
        hit_frame = hit_frame | frames[w];
      end
    end
    any_hit    = |match;
    hit_rank32 = 32'(hit_rank);
  end

  always_comb begin
    pa_frame = any_hit ? hit_frame : ppn;
    pa_wide  = (64'(pa_frame) << PAGE_OFFSET_BITS) | 64'(offset);
  end

  always_comb begin
    row_next   = row;
    valid_next = valid;
    wr_en      = 1'b0;
    res        = '0;
    r          = '0;
    unique case (req)
      satl_pkg::REQ_TRANSLATE: begin
        if (any_hit) begin
          for (int w = 0; w < WAYS; w++) begin
            r = ranks[w];
            if (valid[w] && ranks[w] < hit_rank) begin
              r = ranks[w] + RANK_W'(1);
            end
            if (hit_oh[w]) begin
              r = RANK_W'(1);
            end
            row_next[w*ENT_W +: RANK_W] = r;
          end
          wr_en   = 1'b1;
          res.hit = 1'b1;
          res.pa  = pa_wide[satl_pkg::PA_W-1:0];
        end else if (walk_fault) begin
          res.fault = 1'b1;
        end else begin
          for (int w = 0; w < WAYS; w++) begin
            r = ranks[w];
            if (valid[w]) begin
              r = (ranks[w] < RANK_W'(WAYS)) ? ranks[w] + RANK_W'(1) : RANK_W'(WAYS);
            end
            if (victim_oh[w]) begin
              r = RANK_W'(1);
              valid_next[w] = 1'b1;
              row_next[w*ENT_W + RANK_W +: satl_pkg::FRAME_W] = ppn;
              row_next[w*ENT_W + RANK_W + satl_pkg::FRAME_W +: TAG_W] = tag;
            end
            row_next[w*ENT_W +: RANK_W] = r;
          end
          wr_en  = 1'b1;
          res.pa = pa_wide[satl_pkg::PA_W-1:0];
        end
      end
      satl_pkg::REQ_PEEK: begin
        if (any_hit) begin
          res.hit     = 1'b1;
          res.recency = hit_rank32[satl_pkg::REC_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/set_assoc_tlb_lru.sv
// A request is taken into an input stage register, looked up and updated there,
// and its result is loaded into the output register when that stage fires.
// Throughput: one request per cycle when not stalled; the set row read from RAM is
// bypassed by the row written in the previous cycle when both name the same set.
// Reset clears all valid bits at once; tag, frame and rank storage is not reset.
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru
// Set-associative TLB with per-way recency ranks, fill on a non-faulting miss, peek and clear.
// ----------------------------------------------------------------------------
module set_assoc_tlb_lru #(
  parameter int WAYS             = satl_pkg::DEF_WAYS,
  parameter int SETS             = satl_pkg::DEF_SETS,
  parameter int PAGE_OFFSET_BITS = satl_pkg::DEF_PAGE_OFFSET_BITS,
  parameter int VA_BITS          = satl_pkg::DEF_VA_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // va [47:0], walk_ppn [83:48], walk_fault [84], zero fill [87:85]
  input  logic [satl_pkg::IN_W-1:0]   s_tdata,
  // req_type [1:0]
  input  logic [satl_pkg::REQ_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // pa [47:0], hit [48], fault [49], recency [52:50], zero fill [55:53]
  output logic [satl_pkg::OUT_W-1:0]  m_tdata
);

  localparam int SET_BITS = $clog2(SETS + 1) - 1;
  localparam int NSETS    = 1 << SET_BITS;
  localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int VA_EFF   = (VA_BITS < satl_pkg::VA_W) ? VA_BITS : satl_pkg::VA_W;
  localparam int TAG_RAW  = VA_EFF - PAGE_OFFSET_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int RANK_W   = $clog2(WAYS + 1);
  localparam int ENT_W    = TAG_W + satl_pkg::FRAME_W + RANK_W;
  localparam int ROW_W    = WAYS * ENT_W;
  localparam logic [63:0] VA_MASK = (VA_BITS >= 64) ? '1 : ((64'd1 << VA_BITS) - 64'd1);

  logic [63:0]                  va64;
  logic [63:0]                  vpn64;
  logic [IDX_W-1:0]             in_idx;
  logic [TAG_W-1:0]             in_tag;
  logic [PAGE_OFFSET_BITS-1:0]  in_off;
  logic                         in_fire;

  logic                         s1_valid;
  logic                         s1_fire;
  logic [satl_pkg::REQ_W-1:0]   s1_req;
  logic [IDX_W-1:0]             s1_idx;
  logic [TAG_W-1:0]             s1_tag;
  logic [PAGE_OFFSET_BITS-1:0]  s1_off;
  logic [satl_pkg::FRAME_W-1:0] s1_ppn;
  logic                         s1_wfault;
  logic                         s1_fwd;

  logic [ROW_W-1:0]             ram_rd;
  logic [ROW_W-1:0]             lw_row;
  logic [ROW_W-1:0]             cur_row;
  logic [ROW_W-1:0]             row_next;
  logic [WAYS-1:0]              valid [NSETS];
  logic [WAYS-1:0]              valid_next;
  logic                         lk_wr;
  logic                         any_valid;
  satl_pkg::result_t            res;

  always_comb begin
    va64    = 64'(s_tdata[satl_pkg::VA_W-1:0]) & VA_MASK;
    vpn64   = va64 >> PAGE_OFFSET_BITS;
    in_idx  = IDX_W'(vpn64 & 64'(NSETS - 1));
    in_tag  = TAG_W'(vpn64 >> SET_BITS);
    in_off  = PAGE_OFFSET_BITS'(va64);
    in_fire = s_tvalid && s_tready;
  end

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign cur_row  = s1_fwd ? lw_row : ram_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req    <= s_tuser;
      s1_idx    <= in_idx;
      s1_tag    <= in_tag;
      s1_off    <= in_off;
      s1_ppn    <= s_tdata[satl_pkg::VA_W +: satl_pkg::FRAME_W];
      s1_wfault <= s_tdata[satl_pkg::VA_W + satl_pkg::FRAME_W];
      s1_fwd    <= s1_fire && lk_wr && (s1_idx == in_idx);
    end
    if (s1_fire && lk_wr) begin
      lw_row <= row_next;
    end
  end

  satl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (s1_fire && lk_wr),
    .wr_addr (s1_idx),
    .wr_data (row_next),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .rd_data (ram_rd)
  );

  satl_lookup #(
    .WAYS             (WAYS),
    .TAG_W            (TAG_W),
    .RANK_W           (RANK_W),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
  ) u_lookup (
    .req        (s1_req),
    .tag        (s1_tag),
    .offset     (s1_off),
    .ppn        (s1_ppn),
    .walk_fault (s1_wfault),
    .valid      (valid[s1_idx]),
    .row        (cur_row),
    .row_next   (row_next),
    .valid_next (valid_next),
    .wr_en      (lk_wr),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSETS; s++) begin
        valid[s] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_req == satl_pkg::REQ_CLEAR) begin
        for (int s = 0; s < NSETS; s++) begin
          valid[s] <= '0;
        end
      end else if (lk_wr) begin
        valid[s1_idx] <= valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= {3'b000, res.recency, res.fault, res.hit, res.pa};
    end
  end

  always_comb begin
    any_valid = 1'b0;
    for (int s = 0; s < NSETS; s++) begin
      any_valid = any_valid | (|valid[s]);
    end
  end

`ifndef SYNTHESIS
  a_hit_onehot: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(u_lookup.hit_oh))
    else $error("More than one way selected as the hit way.");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_req == satl_pkg::REQ_CLEAR) |=> !any_valid)
    else $error("Valid ways remain after a clear request.");

  a_hit_fault_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[48] && m_tdata[49]))
    else $error("Result reports both a hit and a fault.");

  a_recency_hit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[52:50] != 3'd0) |-> m_tdata[48])
    else $error("Nonzero recency reported without a hit.");
`endif

endmodule

>>> tb/tb_set_assoc_tlb_lru.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_tlb_lru
// Stream-level test of the 4-way, 16-set TLB with recency ranks. A shadow
// copy of the sets tracks valid bits, tags, frames and ranks, predicts the
// response of every accepted request, and compares the responses in order.
// Directed requests cover the extreme addresses, eviction and every request
// kind. Random traffic then runs over a small pool of hot tags and sets so
// that hits, evictions and rank aging are frequent. Both sides idle at
// several rates.
// ----------------------------------------------------------------------------
module tb_set_assoc_tlb_lru;
  import satl_pkg::*;

  localparam int NUM_WAYS    = DEF_WAYS;
  localparam int NUM_SETS    = DEF_SETS;
  localparam int OFFSET_BITS = DEF_PAGE_OFFSET_BITS;
  localparam int SET_BITS    = $clog2(DEF_SETS);
  localparam int TAG_W       = VA_W - OFFSET_BITS - SET_BITS;
  localparam int HOT_TAGS    = 6;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  class tlb_shadow;
    bit                  valid [NUM_SETS][NUM_WAYS];
    bit [TAG_W-1:0]      tag   [NUM_SETS][NUM_WAYS];
    bit [FRAME_W-1:0]    frame [NUM_SETS][NUM_WAYS];
    bit [REC_W-1:0]      rank  [NUM_SETS][NUM_WAYS];
    result_t             pending_results[$];
    int                  failures;
    int                  shown;

    function void note_request(logic [REQ_W-1:0] req, logic [VA_W-1:0] va,
                               logic [FRAME_W-1:0] ppn, logic walk_fault);
      result_t           r;
      bit [OFFSET_BITS-1:0] off;
      int                set;
      bit [TAG_W-1:0]    t;
      int                hw;
      int                victim;
      bit [REC_W-1:0]    old;
      bit [REC_W-1:0]    maxr;
      r = '0;
      off = va[OFFSET_BITS-1:0];
      set = int'(va[OFFSET_BITS +: SET_BITS]);
      t = va[VA_W-1 -: TAG_W];
      hw = -1;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (hw < 0 && valid[set][w] && tag[set][w] == t) hw = w;
      end
      case (req)
        REQ_CLEAR: begin
          foreach (valid[s, w]) begin
            valid[s][w] = 1'b0;
            rank[s][w] = '0;
          end
        end
        REQ_PEEK: begin
          if (hw >= 0) begin
            r.hit = 1'b1;
            r.recency = rank[set][hw];
          end
        end
        REQ_TRANSLATE: begin
          if (hw >= 0) begin
            old = rank[set][hw];
            for (int w = 0; w < NUM_WAYS; w++) begin
              if (valid[set][w] && rank[set][w] < old) rank[set][w]++;
            end
            rank[set][hw] = REC_W'(1);
            r.hit = 1'b1;
            r.pa = {frame[set][hw], off};
          end else if (walk_fault) begin
            r.fault = 1'b1;
          end else begin
            victim = -1;
            maxr = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
              if (!valid[set][w]) begin
                victim = w;
                break;
              end
              if (rank[set][w] > maxr) begin
                maxr = rank[set][w];
                victim = w;
              end
            end
            if (victim < 0) victim = 0;
            for (int w = 0; w < NUM_WAYS; w++) begin
              if (valid[set][w]) begin
                if (rank[set][w] < NUM_WAYS) rank[set][w]++;
                else rank[set][w] = REC_W'(NUM_WAYS);
              end
            end
            valid[set][victim] = 1'b1;
            tag[set][victim] = t;
            frame[set][victim] = ppn;
            rank[set][victim] = REC_W'(1);
            r.pa = {ppn, off};
          end
        end
        default: begin
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [OUT_W-1:0] data);
      result_t got;
      result_t want;
      got.pa = data[PA_W-1:0];
      got.hit = data[PA_W];
      got.fault = data[PA_W+1];
      got.recency = data[PA_W+2 +: REC_W];
      if (pending_results.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("unexpected response: pa %h hit %b fault %b recency %0d",
                   got.pa, got.hit, got.fault, got.recency);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          failures++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected pa %h hit %b fault %b recency %0d",
                     want.pa, want.hit, want.fault, want.recency);
            $display("          actual   pa %h hit %b fault %b recency %0d",
                     got.pa, got.hit, got.fault, got.recency);
          end
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [REQ_W-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;

  tlb_shadow           board = new;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  quiet_cycles;
  bit [TAG_W-1:0]      hot_tags[HOT_TAGS];

  set_assoc_tlb_lru dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.note_request(s_tuser, s_tdata[VA_W-1:0], s_tdata[VA_W +: FRAME_W],
                           s_tdata[VA_W+FRAME_W]);
      end
      if (m_tvalid && m_tready) begin
        board.check_response(m_tdata);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [VA_W-1:0] make_va(bit [TAG_W-1:0] t, bit [SET_BITS-1:0] set,
                                               bit [OFFSET_BITS-1:0] off);
    return {t, set, off};
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req, logic [VA_W-1:0] va,
                              logic [FRAME_W-1:0] ppn, logic walk_fault);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {3'b000, walk_fault, ppn, va};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_results.size() != 0);
  endtask

  task automatic run_phase(int count, int send_pct, int recv_pct);
    int                  roll;
    logic [REQ_W-1:0]    req;
    logic [VA_W-1:0]     va;
    bit [SET_BITS-1:0]   set;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    foreach (hot_tags[i]) hot_tags[i] = $urandom;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 3) req = REQ_UNUSED;
      else if (roll < 5) req = REQ_CLEAR;
      else if (roll < 35) req = REQ_PEEK;
      else req = REQ_TRANSLATE;
      if ($urandom_range(9) == 0) begin
        va = 48'({$urandom, $urandom});
      end else begin
        set = ($urandom_range(3) == 0) ? SET_BITS'($urandom) : SET_BITS'($urandom_range(3));
        va = make_va(hot_tags[$urandom_range(HOT_TAGS-1)], set, OFFSET_BITS'($urandom));
      end
      send_request(req, va, 36'({$urandom, $urandom}), $urandom_range(6) == 0);
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_TRANSLATE, make_va('0, '0, '0), '0, 1'b0);
    send_request(REQ_TRANSLATE, '1, '1, 1'b0);
    send_request(REQ_PEEK, '1, '0, 1'b0);
    send_request(REQ_TRANSLATE, make_va('0, '0, '1), 36'($urandom), 1'b1);
    send_request(REQ_PEEK, make_va(1, '0, '0), '0, 1'b0);
    send_request(REQ_TRANSLATE, make_va(1, '0, '0), 36'($urandom), 1'b1);
    send_request(REQ_PEEK, make_va(1, '0, '0), '0, 1'b0);
    for (int t = 1; t <= 5; t++) begin
      send_request(REQ_TRANSLATE, make_va(t, '0, OFFSET_BITS'($urandom)), 36'(t), 1'b0);
    end
    for (int t = 0; t <= 5; t++) begin
      send_request(REQ_PEEK, make_va(t, '0, '0), '0, 1'b0);
    end
    send_request(REQ_TRANSLATE, make_va(3, '0, 12'h5a5), 36'($urandom), 1'b0);
    send_request(REQ_PEEK, make_va(3, '0, '0), '0, 1'b0);
    send_request(REQ_UNUSED, 48'({$urandom, $urandom}), 36'({$urandom, $urandom}), 1'b1);
    send_request(REQ_CLEAR, '1, '1, 1'b1);
    send_request(REQ_PEEK, '1, '0, 1'b0);
    send_request(REQ_TRANSLATE, '1, '0, 1'b0);
    wait_for_drain();

    run_phase(420, 0, 0);
    run_phase(420, 81, 0);
    run_phase(420, 0, 81);
    run_phase(420, 37, 37);

    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
